>>> rtl/core/bdg_pkg.sv
package bdg_pkg;

	localparam int COORD_WIDTH      = 32;
	localparam int ANGLE_ITERATIONS = 26;

	localparam int ATAN_ENTRIES   = 40;
	localparam int ATAN_WIDTH     = 30;
	localparam int ITER_IDX_WIDTH = $clog2(ATAN_ENTRIES);
	localparam int DP_WIDTH       = 64;
	localparam int NORM_MSB       = 60;
	localparam int Z_WIDTH        = 34;
	localparam int ZC_WIDTH       = 31;
	localparam int BEARING_WIDTH  = 22;
	localparam int DISTANCE_WIDTH = 40;
	localparam int PROD_WIDTH     = ZC_WIDTH + BEARING_WIDTH;
	localparam int ANGLE_FRAC     = 32;
	localparam int SUM_WIDTH      = 2 * COORD_WIDTH;
	localparam int ROOT_STEPS     = COORD_WIDTH + 8;
	localparam int ROOT_WIDTH     = ROOT_STEPS;
	localparam int RND_WIDTH      = ROOT_WIDTH + 1;
	localparam int REM_WIDTH      = ROOT_STEPS + 2;
	localparam int RAD_WIDTH      = 2 * ROOT_STEPS;

	localparam int FRONT_STAGES = 5;
	localparam int FOLD_STAGES  = 2;
	localparam int LATENCY      = FRONT_STAGES + ANGLE_ITERATIONS + FOLD_STAGES + ROOT_STEPS + 1;

	localparam logic [BEARING_WIDTH-1:0] GON_QUARTER       = 22'd1000000;
	localparam logic [BEARING_WIDTH-1:0] GON_HALF          = 22'd2000000;
	localparam logic [BEARING_WIDTH-1:0] GON_THREE_QUARTER = 22'd3000000;
	localparam logic [BEARING_WIDTH-1:0] GON_FULL          = 22'd4000000;

	localparam logic [ZC_WIDTH-1:0]   Z_RIGHT_ANGLE = 31'h4000_0000;
	localparam logic [PROD_WIDTH-1:0] ROUND_HALF    = 53'h8000_0000;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [ATAN_WIDTH-1:0] ATAN_LUT [ATAN_ENTRIES] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
		30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
		30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
		30'd20,        30'd10,        30'd5,         30'd3,        30'd1,
		30'd1,         30'd0,         30'd0,         30'd0,        30'd0,
		30'd0,         30'd0,         30'd0,         30'd0,        30'd0
	};

	typedef enum logic [2:0] {
		FOLD_Q1,
		FOLD_Q2,
		FOLD_Q3,
		FOLD_Q4,
		FOLD_NORTH,
		FOLD_EAST,
		FOLD_SOUTH,
		FOLD_WEST
	} fold_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] delta_east;
		logic signed [COORD_WIDTH-1:0] delta_north;
	} coord_t;

	typedef struct packed {
		logic [BEARING_WIDTH-1:0]  bearing;
		logic [DISTANCE_WIDTH-1:0] distance;
	} result_t;

	typedef struct packed {
		fold_t                fold;
		logic [SUM_WIDTH-1:0] sum_sq;
	} side_t;

	typedef struct packed {
		logic signed [DP_WIDTH-1:0] x;
		logic signed [DP_WIDTH-1:0] y;
		logic signed [Z_WIDTH-1:0]  z;
		side_t                      side;
	} rot_t;

	typedef struct packed {
		logic [REM_WIDTH-1:0]     rem;
		logic [ROOT_WIDTH-1:0]    root;
		logic [RAD_WIDTH-1:0]     rad;
		logic [BEARING_WIDTH-1:0] bearing;
	} root_t;

endpackage

>>> rtl/core/bdg_front.sv
module bdg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  bdg_pkg::coord_t coord,
	output logic            valid,
	output bdg_pkg::rot_t   rot
);
	import bdg_pkg::*;

	typedef struct packed {
		logic [DP_WIDTH-1:0] m;
		logic [DP_WIDTH-1:0] ax;
		logic [DP_WIDTH-1:0] ay;
	} norm_t;

	function automatic norm_t norm_step(input norm_t v, input int unsigned sh);
		norm_t r;
		r = v;
		if ((v.m >> (NORM_MSB + 1 - sh)) == '0) begin
			r.m  = v.m << sh;
			r.ax = v.ax << sh;
			r.ay = v.ay << sh;
		end
		return r;
	endfunction

	function automatic logic [COORD_WIDTH-1:0] magnitude(input logic [COORD_WIDTH-1:0] v);
		return v[COORD_WIDTH-1] ? (~v + COORD_WIDTH'(1)) : v;
	endfunction

	logic                   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [COORD_WIDTH-1:0] ae_s1, an_s1;
	fold_t                  fold_c, fold_s1, fold_s2;
	logic [SUM_WIDTH-1:0]   sqe_s2, sqn_s2;
	norm_t                  nrm_s2, nrm_s3, nrm_s4, nrm_s5;
	side_t                  side_s3, side_s4, side_s5;
	logic                   ez, nz, es, ns;

	always_comb begin
		ez = (coord.delta_east == '0);
		nz = (coord.delta_north == '0);
		es = coord.delta_east[COORD_WIDTH-1];
		ns = coord.delta_north[COORD_WIDTH-1];
		if (ez && nz) begin
			fold_c = FOLD_NORTH;
		end else if (nz) begin
			fold_c = es ? FOLD_WEST : FOLD_EAST;
		end else if (ez) begin
			fold_c = ns ? FOLD_SOUTH : FOLD_NORTH;
		end else if (!ns && !es) begin
			fold_c = FOLD_Q1;
		end else if (ns && !es) begin
			fold_c = FOLD_Q2;
		end else if (ns && es) begin
			fold_c = FOLD_Q3;
		end else begin
			fold_c = FOLD_Q4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		ae_s1   <= magnitude(coord.delta_east);
		an_s1   <= magnitude(coord.delta_north);
		fold_s1 <= fold_c;

		sqe_s2    <= ae_s1 * ae_s1;
		sqn_s2    <= an_s1 * an_s1;
		fold_s2   <= fold_s1;
		nrm_s2.m  <= DP_WIDTH'((an_s1 > ae_s1) ? an_s1 : ae_s1);
		nrm_s2.ax <= DP_WIDTH'(an_s1);
		nrm_s2.ay <= DP_WIDTH'(ae_s1);

		side_s3.fold   <= fold_s2;
		side_s3.sum_sq <= sqe_s2 + sqn_s2;
		nrm_s3         <= norm_step(norm_step(nrm_s2, 32), 16);

		side_s4 <= side_s3;
		nrm_s4  <= norm_step(norm_step(nrm_s3, 8), 4);

		side_s5 <= side_s4;
		nrm_s5  <= norm_step(norm_step(nrm_s4, 2), 1);
	end

	assign valid    = valid_s5;
	assign rot.x    = signed'(nrm_s5.ax);
	assign rot.y    = signed'(nrm_s5.ay);
	assign rot.z    = '0;
	assign rot.side = side_s5;

endmodule

>>> rtl/core/bdg_rot_cell.sv
module bdg_rot_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [bdg_pkg::ITER_IDX_WIDTH-1:0] idx,
	input  logic                               up_valid,
	input  bdg_pkg::rot_t                      up,
	output logic                               dn_valid,
	output bdg_pkg::rot_t                      dn
);
	import bdg_pkg::*;

	logic signed [DP_WIDTH-1:0] x_c, y_c, xs, ys;
	logic signed [Z_WIDTH-1:0]  z_c, step_z;
	rot_t                       nxt;
	logic                       valid_q;
	rot_t                       data_q;

	always_comb begin
		x_c    = up.x;
		y_c    = up.y;
		z_c    = up.z;
		xs     = x_c >>> idx;
		ys     = y_c >>> idx;
		step_z = signed'({{(Z_WIDTH - ATAN_WIDTH){1'b0}}, ATAN_LUT[idx]});
		nxt    = up;
		if (y_c[DP_WIDTH-1]) begin
			nxt.x = x_c - ys;
			nxt.y = y_c + xs;
			nxt.z = z_c - step_z;
		end else begin
			nxt.x = x_c + ys;
			nxt.y = y_c - xs;
			nxt.z = z_c + step_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign dn_valid = valid_q;
	assign dn       = data_q;

endmodule

>>> rtl/core/bdg_fold.sv
module bdg_fold (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	input  bdg_pkg::rot_t  up,
	output logic           dn_valid,
	output bdg_pkg::root_t dn
);
	import bdg_pkg::*;

	logic signed [Z_WIDTH-1:0]  z_c;
	logic [ZC_WIDTH-1:0]        zc;
	logic                       valid_s1, valid_s2;
	logic [PROD_WIDTH-1:0]      prod_s1;
	side_t                      side_s1;
	logic [BEARING_WIDTH-1:0]   theta, raw, bearing_c;
	root_t                      data_s2;

	always_comb begin
		z_c = up.z;
		if (z_c < 0) begin
			zc = '0;
		end else if (z_c > signed'({{(Z_WIDTH - ZC_WIDTH){1'b0}}, Z_RIGHT_ANGLE})) begin
			zc = Z_RIGHT_ANGLE;
		end else begin
			zc = z_c[ZC_WIDTH-1:0];
		end
	end

	always_comb begin
		theta = BEARING_WIDTH'((prod_s1 + ROUND_HALF) >> ANGLE_FRAC);
		case (side_s1.fold)
			FOLD_Q1:    raw = theta;
			FOLD_Q2:    raw = GON_HALF - theta;
			FOLD_Q3:    raw = GON_HALF + theta;
			FOLD_Q4:    raw = GON_FULL - theta;
			FOLD_NORTH: raw = '0;
			FOLD_EAST:  raw = GON_QUARTER;
			FOLD_SOUTH: raw = GON_HALF;
			FOLD_WEST:  raw = GON_THREE_QUARTER;
			default:    raw = '0;
		endcase
		bearing_c = (raw >= GON_FULL) ? (raw - GON_FULL) : raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1         <= zc * GON_FULL;
		side_s1         <= up.side;
		data_s2.rem     <= '0;
		data_s2.root    <= '0;
		data_s2.rad     <= {side_s1.sum_sq, {(RAD_WIDTH - SUM_WIDTH){1'b0}}};
		data_s2.bearing <= bearing_c;
	end

	assign dn_valid = valid_s2;
	assign dn       = data_s2;

endmodule

>>> rtl/core/bdg_sqrt_cell.sv
module bdg_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	input  bdg_pkg::root_t up,
	output logic           dn_valid,
	output bdg_pkg::root_t dn
);
	import bdg_pkg::*;

	logic [REM_WIDTH-1:0] remx, trial;
	root_t                nxt;
	logic                 valid_q;
	root_t                data_q;

	always_comb begin
		remx  = {up.rem[REM_WIDTH-3:0], up.rad[RAD_WIDTH-1 -: 2]};
		trial = {up.root, 2'b01};
		nxt   = up;
		if (remx >= trial) begin
			nxt.rem  = remx - trial;
			nxt.root = {up.root[ROOT_WIDTH-2:0], 1'b1};
		end else begin
			nxt.rem  = remx;
			nxt.root = {up.root[ROOT_WIDTH-2:0], 1'b0};
		end
		nxt.rad = up.rad << 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign dn_valid = valid_q;
	assign dn       = data_q;

endmodule

>>> rtl/core/bearing_and_distance_gon_unit.sv
// channel   | handshake         | word
// ----------+-------------------+--------------------------------------
// coord     | start, busy       | delta_east, delta_north (signed)
// result    | done (strobe)     | bearing (1/10000 gon), distance (Q.8)
//
// Fully pipelined: one word accepted per cycle, busy is always low.
// Each word passes through the front end, the rotation cell row, the fold registers,
// the square-root cell row and the result register.
// arst_n clears all valid bits; words in flight are dropped.
// done is high for one cycle per word; the receiver cannot stall.
module bearing_and_distance_gon_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bdg_pkg::coord_t  coord,
	output logic             busy,
	output logic             done,
	output bdg_pkg::result_t result
);
	import bdg_pkg::*;

	logic                  take;
	logic                  rot_link_valid [ANGLE_ITERATIONS+1];
	rot_t                  rot_link       [ANGLE_ITERATIONS+1];
	logic                  root_link_valid [ROOT_STEPS+1];
	root_t                 root_link       [ROOT_STEPS+1];
	root_t                 last;
	logic                  inc;
	logic [RND_WIDTH-1:0]  rounded;
	logic                  done_q;
	result_t               result_q;

	assign busy = 1'b0;
	assign take = start & ~busy;

	bdg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.coord  (coord),
		.valid  (rot_link_valid[0]),
		.rot    (rot_link[0])
	);

	for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_rot
		bdg_rot_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (ITER_IDX_WIDTH'(i)),
			.up_valid (rot_link_valid[i]),
			.up       (rot_link[i]),
			.dn_valid (rot_link_valid[i+1]),
			.dn       (rot_link[i+1])
		);
	end

	bdg_fold u_fold (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (rot_link_valid[ANGLE_ITERATIONS]),
		.up       (rot_link[ANGLE_ITERATIONS]),
		.dn_valid (root_link_valid[0]),
		.dn       (root_link[0])
	);

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_sqrt
		bdg_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (root_link_valid[j]),
			.up       (root_link[j]),
			.dn_valid (root_link_valid[j+1]),
			.dn       (root_link[j+1])
		);
	end

	// round to nearest: remainder above root means the half bit is set
	always_comb begin
		last    = root_link[ROOT_STEPS];
		inc     = (last.rem > {2'b00, last.root});
		rounded = {1'b0, last.root} + RND_WIDTH'(inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= root_link_valid[ROOT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		result_q.bearing  <= last.bearing;
		result_q.distance <= DISTANCE_WIDTH'(rounded);
	end

	assign done   = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##LATENCY done)
		else $error("word accepted but no result after pipeline latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, LATENCY))
		else $error("result without matching accepted word");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.bearing < GON_FULL))
		else $error("bearing not wrapped below full turn");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(take && (coord.delta_east == '0) && (coord.delta_north == '0), LATENCY)
		|-> (result == '0))
		else $error("zero vector gave nonzero result");

endmodule
